>>> design/hpfj_pkg.sv
// hpfj_pkg: shared types and constants for the hamiltonian path solver
`default_nettype none
package hpfj_pkg;

   localparam int LEN_W      = 16;
   localparam int COST_W     = 20;
   localparam int OUT_W      = 19;
   localparam int NODE_IN_W  = 3;
   localparam int EDGE_IDX_W = 2 * NODE_IN_W;
   localparam int CSR_W      = 4;
   localparam int CSR_IDX_W  = 1;

   localparam logic [COST_W-1:0] COST_INF = '1;
   localparam logic [OUT_W-1:0]  OUT_MAX  = '1;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_SOLVE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_JUMPS  = 1'd1;

   localparam logic [CSR_W-1:0] NODE_COUNT_RST = 4'd8;
   localparam logic [CSR_W-1:0] MAX_JUMPS_RST  = 4'd0;

   typedef struct packed {
      logic                 command;
      logic [NODE_IN_W-1:0] from_node;
      logic [NODE_IN_W-1:0] to_node;
      logic [LEN_W-1:0]     edge_length;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] path_cost;
      logic             found;
   } rsp_type;

   typedef struct packed {
      logic                 en;
      logic [NODE_IN_W-1:0] a;
      logic [NODE_IN_W-1:0] b;
      logic [LEN_W-1:0]     len;
   } edge_add_type;

   typedef struct packed {
      logic                 clear;
      logic [NODE_IN_W-1:0] a;
      logic [NODE_IN_W-1:0] b;
   } edge_rd_type;

   typedef struct packed {
      logic             hit;
      logic [LEN_W-1:0] len;
   } edge_rsp_type;

   typedef struct packed {
      logic start;
      logic take;
   } eng_ctl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [COST_W-1:0] best;
   } eng_sts_type;

endpackage
`default_nettype wire

>>> design/hpfj_edge_store.sv
// hpfj_edge_store: edge length memory with valid flags and keep-the-shorter update
`default_nettype none
module hpfj_edge_store (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hpfj_pkg::edge_add_type add_i,
   input  wire hpfj_pkg::edge_rd_type  rd_i,
   output hpfj_pkg::edge_rsp_type      rsp_o
);
   import hpfj_pkg::*;

   localparam int ENTRIES = 1 << EDGE_IDX_W;

   function automatic logic [EDGE_IDX_W-1:0] pair_idx(input logic [NODE_IN_W-1:0] a,
                                                      input logic [NODE_IN_W-1:0] b);
      return (a < b) ? {a, b} : {b, a};
   endfunction

   logic [LEN_W-1:0]      len_mem [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [EDGE_IDX_W-1:0] raddr;
   logic [LEN_W-1:0]      rd_len_ff;
   logic                  rd_hit_ff;
   logic                  s1_en_ff;
   logic [EDGE_IDX_W-1:0] s1_idx_ff;
   logic [LEN_W-1:0]      s1_len_ff;
   logic                  wr_en_ff;
   logic [EDGE_IDX_W-1:0] wr_idx_ff;
   logic [LEN_W-1:0]      wr_len_ff;
   logic [LEN_W-1:0]      old_len, new_len;
   logic                  old_valid;

   assign raddr     = add_i.en ? pair_idx(add_i.a, add_i.b) : pair_idx(rd_i.a, rd_i.b);
   // forward the write of the previous beat when it hits the same pair
   assign old_len   = (wr_en_ff && (wr_idx_ff == s1_idx_ff)) ? wr_len_ff : rd_len_ff;
   assign old_valid = valid_ff[s1_idx_ff];
   assign new_len   = (old_valid && (old_len < s1_len_ff)) ? old_len : s1_len_ff;

   always_comb begin
      valid_in = valid_ff;
      if (rd_i.clear) begin
         valid_in = '0;
      end else if (s1_en_ff) begin
         valid_in[s1_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         s1_en_ff <= 1'b0;
         wr_en_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         s1_en_ff <= add_i.en;
         wr_en_ff <= s1_en_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= pair_idx(add_i.a, add_i.b);
      s1_len_ff <= add_i.len;
      wr_idx_ff <= s1_idx_ff;
      wr_len_ff <= new_len;
      rd_hit_ff <= valid_ff[raddr];
      rd_len_ff <= len_mem[raddr];
      if (s1_en_ff) begin
         len_mem[s1_idx_ff] <= new_len;
      end
   end

   assign rsp_o.hit = rd_hit_ff;
   assign rsp_o.len = rd_len_ff;

   a_no_clear_during_add: assert property (@(posedge clock) disable iff (reset)
      rd_i.clear |-> !s1_en_ff)
      else $error("edge clear collides with an edge update");

   a_add_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (s1_en_ff && !rd_i.clear) |=> $countones(valid_ff) != 0)
      else $error("edge update left no valid entry");

endmodule
`default_nettype wire

>>> design/hpfj_dp_engine.sv
// hpfj_dp_engine: subset dynamic program over the cost memory, one transition per cycle in the run state
`default_nettype none
module hpfj_dp_engine #(
   parameter int NODES = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hpfj_pkg::eng_ctl_type         ctl_i,
   input  wire logic [$clog2(NODES+1)-1:0]    n_i,
   input  wire logic [$clog2(NODES+1)-1:0]    k_i,
   input  wire hpfj_pkg::edge_rsp_type        edge_i,
   output hpfj_pkg::edge_rd_type              edge_o,
   output hpfj_pkg::eng_sts_type              sts_o
);
   import hpfj_pkg::*;

   localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CNT_W  = $clog2(NODES + 1);
   localparam int ADDR_W = NODES + NODE_W + CNT_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int EXT_W  = ((NODE_W > NODE_IN_W) ? NODE_W : NODE_IN_W) + 1;
   localparam int WAIT_W = 2;
   localparam logic [WAIT_W-1:0] WAIT_LAST = 2'd2;
   localparam logic [EXT_W-1:0]  EDGE_LIM  = EXT_W'(1 << NODE_IN_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [COST_W-1:0] cost_mem [DEPTH];

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  n_ff, n_in, k_ff, k_in, tel_ff, tel_in, prev_lim;
   logic [NODES-1:0]  full_ff, full_in, mask_ff, mask_in, pm;
   logic [NODES:0]    full_wide;
   logic [NODE_W-1:0] lst_ff, lst_in, prev_ff, prev_in;
   logic              fin_ff, fin_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic              issue, prev_end, tel_end, lst_end, a_pv, a_lok, a_eok;
   logic [EXT_W-1:0]  prev_x, lst_x;
   logic [ADDR_W-1:0] addr_a, addr_b, addr_w;

   logic              b_vld_ff, b_fin_ff, b_pv_ff, b_lok_ff, b_first_ff, b_last_ff;
   logic              b_base_ff, b_tel0_ff, b_eok_ff;
   logic [ADDR_W-1:0] b_wadr_ff;
   logic [COST_W-1:0] rd_a_ff, rd_b_ff;
   logic [COST_W:0]   sum;
   logic [COST_W-1:0] edge_cost, cand_e, cand_j, cand;

   logic              c_vld_ff, c_fin_ff, c_lok_ff, c_first_ff, c_last_ff, c_base_ff, c_tel0_ff;
   logic [ADDR_W-1:0] c_wadr_ff;
   logic [COST_W-1:0] c_cand_ff, acc_ff, tot, wdata;
   logic              mem_we;

   // issue stage
   assign issue     = (state_ff == ST_RUN);
   assign pm        = mask_ff & ~(NODES'(1) << lst_ff);
   assign prev_lim  = fin_ff ? '0 : n_ff - CNT_W'(1);
   assign prev_end  = (CNT_W'(prev_ff) == prev_lim);
   assign tel_end   = (tel_ff == k_ff);
   assign lst_end   = (CNT_W'(lst_ff) == n_ff - CNT_W'(1));
   assign a_lok     = mask_ff[lst_ff];
   assign a_pv      = mask_ff[prev_ff] && (prev_ff != lst_ff);
   assign prev_x    = EXT_W'(prev_ff);
   assign lst_x     = EXT_W'(lst_ff);
   assign a_eok     = (prev_x < EDGE_LIM) && (lst_x < EDGE_LIM);
   assign addr_a    = fin_ff ? {mask_ff, lst_ff, tel_ff} : {pm, prev_ff, tel_ff};
   assign addr_b    = {pm, prev_ff, tel_ff - CNT_W'(1)};
   assign addr_w    = {mask_ff, lst_ff, tel_ff};
   assign full_wide = ((NODES+1)'(1) << n_i) - (NODES+1)'(1);

   assign edge_o.a     = prev_x[NODE_IN_W-1:0];
   assign edge_o.b     = lst_x[NODE_IN_W-1:0];
   assign edge_o.clear = (state_ff == ST_DONE) && ctl_i.take;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      full_in  = full_ff;
      mask_in  = mask_ff;
      lst_in   = lst_ff;
      tel_in   = tel_ff;
      prev_in  = prev_ff;
      fin_in   = fin_ff;
      wait_in  = wait_ff;
      best_in  = best_ff;
      if (c_vld_ff && c_fin_ff && (c_cand_ff < best_ff)) begin
         best_in = c_cand_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            if (ctl_i.start) begin
               n_in     = n_i;
               k_in     = k_i;
               full_in  = full_wide[NODES-1:0];
               mask_in  = NODES'(1);
               lst_in   = '0;
               tel_in   = '0;
               prev_in  = '0;
               fin_in   = 1'b0;
               wait_in  = '0;
               best_in  = COST_INF;
               state_in = (n_i == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (prev_end) begin
               prev_in = '0;
               if (tel_end) begin
                  tel_in = '0;
                  if (lst_end) begin
                     lst_in   = '0;
                     wait_in  = WAIT_LAST;
                     state_in = ST_WAIT;
                  end else begin
                     lst_in = lst_ff + NODE_W'(1);
                  end
               end else begin
                  tel_in = tel_ff + CNT_W'(1);
               end
            end else begin
               prev_in = prev_ff + NODE_W'(1);
            end
         end
         ST_WAIT: begin
            // hold off the next subset until the last write-back has landed
            if (wait_ff != '0) begin
               wait_in = wait_ff - WAIT_W'(1);
            end else if (fin_ff) begin
               state_in = ST_DONE;
            end else if (mask_ff == full_ff) begin
               fin_in   = 1'b1;
               state_in = ST_RUN;
            end else begin
               mask_in  = mask_ff + NODES'(1);
               state_in = ST_RUN;
            end
         end
         ST_DONE: begin
            if (ctl_i.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         wait_ff  <= '0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         wait_ff  <= wait_in;
         b_vld_ff <= issue;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      k_ff    <= k_in;
      full_ff <= full_in;
      mask_ff <= mask_in;
      lst_ff  <= lst_in;
      tel_ff  <= tel_in;
      prev_ff <= prev_in;
      best_ff <= best_in;
   end

   // read stage
   always_ff @(posedge clock) begin
      b_fin_ff   <= fin_ff;
      b_pv_ff    <= a_pv;
      b_lok_ff   <= a_lok;
      b_first_ff <= (prev_ff == '0);
      b_last_ff  <= prev_end;
      b_base_ff  <= (pm == '0);
      b_tel0_ff  <= (tel_ff == '0);
      b_eok_ff   <= a_eok;
      b_wadr_ff  <= addr_w;
   end

   assign sum       = {1'b0, rd_a_ff} + (COST_W+1)'(edge_i.len);
   assign edge_cost = ((rd_a_ff == COST_INF) || (sum >= (COST_W+1)'(COST_INF))) ?
                      COST_INF : sum[COST_W-1:0];
   assign cand_e    = (b_pv_ff && b_eok_ff && edge_i.hit) ? edge_cost : COST_INF;
   assign cand_j    = (b_pv_ff && !b_tel0_ff) ? rd_b_ff : COST_INF;
   assign cand      = b_fin_ff ? rd_a_ff : ((cand_j < cand_e) ? cand_j : cand_e);

   // combine and write-back stage
   always_ff @(posedge clock) begin
      c_fin_ff   <= b_fin_ff;
      c_lok_ff   <= b_lok_ff;
      c_first_ff <= b_first_ff;
      c_last_ff  <= b_last_ff;
      c_base_ff  <= b_base_ff;
      c_tel0_ff  <= b_tel0_ff;
      c_wadr_ff  <= b_wadr_ff;
      c_cand_ff  <= cand;
      acc_ff     <= tot;
   end

   assign tot    = (c_first_ff || (c_cand_ff < acc_ff)) ? c_cand_ff : acc_ff;
   assign mem_we = c_vld_ff && !c_fin_ff && c_last_ff && c_lok_ff;
   // single-node subsets start at zero cost with no jumps used
   assign wdata  = c_base_ff ? (c_tel0_ff ? '0 : COST_INF) : tot;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cost_mem[c_wadr_ff] <= wdata;
      end
      rd_a_ff <= cost_mem[addr_a];
      rd_b_ff <= cost_mem[addr_b];
   end

   assign sts_o.busy = (state_ff != ST_IDLE);
   assign sts_o.done = (state_ff == ST_DONE);
   assign sts_o.best = best_ff;

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!b_vld_ff && !c_vld_ff))
      else $error("result offered while the pipeline still holds work");

   a_write_current_subset: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (c_wadr_ff[ADDR_W-1 -: NODES] == mask_ff))
      else $error("write-back lands after the subset counter moved on");

   a_write_while_active: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_RUN) || (state_ff == ST_WAIT)))
      else $error("cost memory written outside a solve");

endmodule
`default_nettype wire

>>> design/hamiltonian_path_with_free_jumps.sv
// hamiltonian_path_with_free_jumps: top level, handshake, configuration and result register
`default_nettype none
// Edge beats (command 0) are taken one per cycle while no solve is busy; a pair given twice
// keeps the shorter length, and ends at or beyond NODES are dropped. A solve beat (command 1)
// stalls the request side while the subset program walks the cost memory, one transition per
// cycle outside the waits between subsets, for n = min(node_count, NODES) and
// k = min(max_jumps, NODES), in a single read/write pass over the cost memory
// (2^(NODES + clog2(NODES) + clog2(NODES+1)) words of 20 bits, every word written before it
// is read, so there is no clearing pass). A node count of zero goes straight to the result.
// The result sits in an output register, and the edge table is cleared to all-absent as the
// result is handed over. Configuration takes effect at the next solve.
module hamiltonian_path_with_free_jumps #(
   parameter int NODES = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire hpfj_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output hpfj_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [hpfj_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hpfj_pkg::CSR_W-1:0]         csr_wdata
);
   import hpfj_pkg::*;

   localparam int CNT_W = $clog2(NODES + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int LIM_W = (CNT_W > NODE_IN_W) ? CNT_W : NODE_IN_W;
   localparam logic [CMP_W-1:0] NODES_C = CMP_W'(NODES);
   localparam logic [LIM_W-1:0] NODES_L = LIM_W'(NODES);

   logic [CSR_W-1:0]  node_count_ff, node_count_in, max_jumps_ff, max_jumps_in;
   logic [CMP_W-1:0]  nc_x, mj_x;
   logic [CNT_W-1:0]  n_clamp, k_clamp;
   logic              req_fire;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   edge_add_type      edge_add;
   edge_rd_type       edge_rd;
   edge_rsp_type      edge_rsp;
   eng_ctl_type       eng_ctl;
   eng_sts_type       eng_sts;
   logic              found;

   assign req_stall = eng_sts.busy;
   assign req_fire  = req_valid && !req_stall;

   assign nc_x    = CMP_W'(node_count_ff);
   assign mj_x    = CMP_W'(max_jumps_ff);
   assign n_clamp = (nc_x > NODES_C) ? NODES_C[CNT_W-1:0] : nc_x[CNT_W-1:0];
   assign k_clamp = (mj_x > NODES_C) ? NODES_C[CNT_W-1:0] : mj_x[CNT_W-1:0];

   assign edge_add.en  = req_fire && (req_data.command == CMD_ADD) &&
                         (LIM_W'(req_data.from_node) < NODES_L) &&
                         (LIM_W'(req_data.to_node) < NODES_L);
   assign edge_add.a   = req_data.from_node;
   assign edge_add.b   = req_data.to_node;
   assign edge_add.len = req_data.edge_length;

   assign eng_ctl.start = req_fire && (req_data.command == CMD_SOLVE);
   assign eng_ctl.take  = eng_sts.done && (!rsp_valid_ff || !rsp_stall);

   hpfj_edge_store u_edge_store (
      .clock (clock),
      .reset (reset),
      .add_i (edge_add),
      .rd_i  (edge_rd),
      .rsp_o (edge_rsp)
   );

   hpfj_dp_engine #(
      .NODES (NODES)
   ) u_dp_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl_i  (eng_ctl),
      .n_i    (n_clamp),
      .k_i    (k_clamp),
      .edge_i (edge_rsp),
      .edge_o (edge_rd),
      .sts_o  (eng_sts)
   );

   always_comb begin
      node_count_in = node_count_ff;
      max_jumps_in  = max_jumps_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_in = csr_wdata;
            CSR_MAX_JUMPS:  max_jumps_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign found = (eng_sts.best != COST_INF);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_ctl.take) begin
         rsp_valid_in      = 1'b1;
         rsp_data_in.found = found;
         if (!found) begin
            rsp_data_in.path_cost = '0;
         end else if (eng_sts.best > COST_W'(OUT_MAX)) begin
            rsp_data_in.path_cost = OUT_MAX;
         end else begin
            rsp_data_in.path_cost = eng_sts.best[OUT_W-1:0];
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
         max_jumps_ff  <= MAX_JUMPS_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         max_jumps_ff  <= max_jumps_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
